// ===== design/ehsp_pkg.sv =====
// Shared types, constants and layout tables for the ELF header stream parser.
package ehsp_pkg;

   localparam int IdentBytes = 16;
   localparam int NumFields  = 13;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_HEADER,
      PHASE_PADDING,
      PHASE_FINISHED
   } phase_type;

   typedef enum logic [3:0] {
      STATUS_OK               = 4'd0,
      STATUS_BAD_MAGIC        = 4'd1,
      STATUS_NO_CLASS         = 4'd2,
      STATUS_UNKNOWN_CLASS    = 4'd3,
      STATUS_BAD_ENCODING     = 4'd4,
      STATUS_VERSION_MISMATCH = 4'd5,
      STATUS_BAD_VERSION      = 4'd6,
      STATUS_TOO_SHORT        = 4'd7,
      STATUS_TRUNCATED        = 4'd8
   } status_type;

   // Field codes that need special handling
   localparam logic [3:0] FieldVersion = 4'd2;
   localparam logic [3:0] FieldEhsize  = 4'd7;

   // Identification byte offsets
   localparam logic [15:0] IdentClassPos   = 16'd4;
   localparam logic [15:0] IdentDataPos    = 16'd5;
   localparam logic [15:0] IdentVersionPos = 16'd6;
   localparam logic [15:0] MagicBytes      = 16'd4;

   // Identification byte codes
   localparam logic [7:0] ClassNone = 8'd0;
   localparam logic [7:0] Class32   = 8'd1;
   localparam logic [7:0] Class64   = 8'd2;
   localparam logic [7:0] DataLsb   = 8'd1;
   localparam logic [7:0] DataMsb   = 8'd2;

   localparam logic [63:0] ExpectedVersion = 64'd1;

   localparam logic [7:0] Magic [4] = '{8'h7F, 8'h45, 8'h4C, 8'h46};

   // Field start and length within the body, per class (32-bit row, 64-bit row)
   localparam logic [5:0] FieldStart [2][NumFields] = '{
      '{6'd0, 6'd2, 6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd26, 6'd28, 6'd30,
        6'd32, 6'd34},
      '{6'd0, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32, 6'd36, 6'd38, 6'd40, 6'd42,
        6'd44, 6'd46}};
   localparam logic [3:0] FieldLen [2][NumFields] = '{
      '{4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2},
      '{4'd2, 4'd2, 4'd4, 4'd8, 4'd8, 4'd8, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2}};

   // Full header length (identification plus body), per class
   localparam logic [15:0] TotalLen [2] = '{16'd52, 16'd64};

   typedef struct packed {
      phase_type   phase;
      logic [15:0] offset;
      logic        class_wide;
      logic        msb_first;
      logic [7:0]  ident_version;
      logic [63:0] acc;
      logic [15:0] hdr_len;
   } state_type;

   localparam state_type ResetState = '{
      PHASE_IDLE, 16'd0, 1'b0, 1'b0, 8'd0, 64'd0, 16'd0};

   typedef struct packed {
      logic        emit;
      logic [3:0]  field_id;
      logic [63:0] field_value;
      logic        field_valid;
      status_type  status;
      logic        is_64bit;
      logic        big_endian;
      logic        header_done;
   } result_type;

endpackage

// ===== design/ehsp_step.sv =====
// Per-byte parse step: next parser state and the result caused by one byte.
module ehsp_step (
   input  ehsp_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 first_byte,
   input  logic                 end_of_data,
   output ehsp_pkg::state_type  state_nxt,
   output ehsp_pkg::result_type result
);

   ehsp_pkg::state_type  st;
   ehsp_pkg::status_type status;
   logic [5:0]           rel;
   logic [3:0]           fidx;
   logic [2:0]           kidx;
   logic                 cw;
   logic                 field_last;
   logic [63:0]          acc_base;
   logic [63:0]          acc_new;
   logic [15:0]          pos_next;
   logic                 header_end;

   always_comb begin
      st = state_cur;
      if (first_byte) begin
         st       = ehsp_pkg::ResetState;
         st.phase = ehsp_pkg::PHASE_HEADER;
      end
      state_nxt  = st;
      result     = '0;
      status     = ehsp_pkg::STATUS_OK;
      header_end = 1'b0;
      cw         = st.class_wide;

      // Locate the field and byte within it
      rel  = st.offset[5:0] - 6'(ehsp_pkg::IdentBytes);
      fidx = '0;
      kidx = '0;
      for (int i = 0; i < ehsp_pkg::NumFields; i++) begin
         if (rel >= ehsp_pkg::FieldStart[cw][i] &&
             rel < ehsp_pkg::FieldStart[cw][i] + 6'(ehsp_pkg::FieldLen[cw][i])) begin
            fidx = 4'(i);
            kidx = 3'(rel - ehsp_pkg::FieldStart[cw][i]);
         end
      end
      field_last = ({1'b0, kidx} + 4'd1) == ehsp_pkg::FieldLen[cw][fidx];
      acc_base   = (kidx == 3'd0) ? 64'd0 : st.acc;
      acc_new    = st.msb_first ? {acc_base[55:0], data_byte}
                                : acc_base | ({56'd0, data_byte} << {kidx, 3'b000});
      pos_next   = st.offset + 16'd1;

      case (st.phase)
         ehsp_pkg::PHASE_PADDING: begin
            state_nxt.offset = pos_next;
            if (pos_next >= st.hdr_len || end_of_data) begin
               result.emit        = 1'b1;
               result.header_done = 1'b1;
               state_nxt.phase    = ehsp_pkg::PHASE_FINISHED;
            end
         end
         ehsp_pkg::PHASE_HEADER: begin
            if (st.offset < 16'(ehsp_pkg::IdentBytes)) begin
               if (st.offset < ehsp_pkg::MagicBytes) begin
                  if (data_byte != ehsp_pkg::Magic[st.offset[1:0]])
                     status = ehsp_pkg::STATUS_BAD_MAGIC;
               end else if (st.offset == ehsp_pkg::IdentClassPos) begin
                  case (data_byte)
                     ehsp_pkg::Class32:   state_nxt.class_wide = 1'b0;
                     ehsp_pkg::Class64:   state_nxt.class_wide = 1'b1;
                     ehsp_pkg::ClassNone: status = ehsp_pkg::STATUS_NO_CLASS;
                     default:             status = ehsp_pkg::STATUS_UNKNOWN_CLASS;
                  endcase
               end else if (st.offset == ehsp_pkg::IdentDataPos) begin
                  case (data_byte)
                     ehsp_pkg::DataLsb: state_nxt.msb_first = 1'b0;
                     ehsp_pkg::DataMsb: state_nxt.msb_first = 1'b1;
                     default:           status = ehsp_pkg::STATUS_BAD_ENCODING;
                  endcase
               end else if (st.offset == ehsp_pkg::IdentVersionPos) begin
                  state_nxt.ident_version = data_byte;
               end
            end else begin
               state_nxt.acc = acc_new;
               if (field_last) begin
                  result.emit        = 1'b1;
                  result.field_valid = 1'b1;
                  result.field_id    = fidx;
                  result.field_value = acc_new;
                  if (fidx == ehsp_pkg::FieldVersion) begin
                     // Mismatch with the identification byte wins over the value check
                     if (acc_new != {56'd0, st.ident_version})
                        status = ehsp_pkg::STATUS_VERSION_MISMATCH;
                     else if (acc_new != ehsp_pkg::ExpectedVersion)
                        status = ehsp_pkg::STATUS_BAD_VERSION;
                  end else if (fidx == ehsp_pkg::FieldEhsize) begin
                     state_nxt.hdr_len = acc_new[15:0];
                  end
               end
               if (pos_next == ehsp_pkg::TotalLen[cw] && status == ehsp_pkg::STATUS_OK) begin
                  header_end = 1'b1;
                  if (state_nxt.hdr_len < ehsp_pkg::TotalLen[cw]) begin
                     status = ehsp_pkg::STATUS_TOO_SHORT;
                  end else if (state_nxt.hdr_len == ehsp_pkg::TotalLen[cw]) begin
                     result.emit        = 1'b1;
                     result.header_done = 1'b1;
                     state_nxt.phase    = ehsp_pkg::PHASE_FINISHED;
                  end else begin
                     state_nxt.phase = ehsp_pkg::PHASE_PADDING;
                  end
               end
            end
            state_nxt.offset = pos_next;
            if (status == ehsp_pkg::STATUS_OK && !header_end && end_of_data)
               status = ehsp_pkg::STATUS_TRUNCATED;
            if (status != ehsp_pkg::STATUS_OK) begin
               result.emit        = 1'b1;
               result.header_done = 1'b1;
               state_nxt.phase    = ehsp_pkg::PHASE_FINISHED;
            end
         end
         default: begin
            // Idle or finished without a restart: drop the byte
            state_nxt = st;
         end
      endcase

      result.status     = status;
      result.is_64bit   = state_nxt.class_wide;
      result.big_endian = state_nxt.msb_first;
   end

endmodule

// ===== design/elf_header_stream_parser_core.sv =====
// Top level of the ELF header stream parser: input register, parse state, result register.
// An accepted byte's result, if any, is registered once the result register is free.
// Throughput: one byte per cycle unless rsp_stall holds the result register; the parse step
//   is a single combinational pass between the input register and the result register,
//   with the parse state updated alongside.
// Reset (synchronous, active high): clears both valid flags and returns the parser to idle.
module elf_header_stream_parser_core (
   input  logic        clock,
   input  logic        reset,
   // Byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_end_of_data,
   // Field results out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_id,
   output logic [63:0] rsp_field_value,
   output logic        rsp_field_valid,
   output logic [3:0]  rsp_status,
   output logic        rsp_is_64bit,
   output logic        rsp_big_endian,
   output logic        rsp_header_done
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   // Parser state
   ehsp_pkg::state_type state_ff, state_in;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   ehsp_pkg::result_type out_ff;

   ehsp_pkg::result_type step_result;
   logic                 out_free;
   logic                 advance;
   logic                 req_xfer;

   // The result register can take a new entry when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Process the held byte only when its result has somewhere to go
   assign advance   = in_valid_ff && out_free;
   // Hold off the producer only when the input register is full and cannot move
   assign req_stall = in_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   ehsp_step u_step (
      .state_cur   (state_ff),
      .data_byte   (in_data_ff),
      .first_byte  (in_first_ff),
      .end_of_data (in_last_ff),
      .state_nxt   (state_in),
      .result      (step_result)
   );

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   // Load a new result when the step emits; otherwise hold while stalled, else drop
   assign out_valid_in = (advance && step_result.emit) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ehsp_pkg::ResetState;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_end_of_data;
      end
      if (advance && step_result.emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_id    = out_ff.field_id;
   assign rsp_field_value = out_ff.field_value;
   assign rsp_field_valid = out_ff.field_valid;
   assign rsp_status      = out_ff.status;
   assign rsp_is_64bit    = out_ff.is_64bit;
   assign rsp_big_endian  = out_ff.big_endian;
   assign rsp_header_done = out_ff.header_done;

endmodule

// ===== design/ehsp_checker.sv =====
// Port-level checker for the ELF header stream parser, bound to the top level.
module ehsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_field_valid,
   input logic [3:0] rsp_status,
   input logic       rsp_header_done
);

   // No result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high in the cycle after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A result without a field only reports the end of the header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_field_valid |-> rsp_header_done)
      else $error("empty result without header_done");

   // Any error finishes the header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ehsp_pkg::STATUS_OK |-> rsp_header_done)
      else $error("error status without header_done");

endmodule

bind elf_header_stream_parser_core ehsp_checker u_ehsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_field_valid (rsp_field_valid),
   .rsp_status      (rsp_status),
   .rsp_header_done (rsp_header_done)
);
